// ----- design/mpic_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mpic_pkg
// Shared types and constants of the multiprocessor interrupt controller.
// ----------------------------------------------------------------------------
package mpic_pkg;

	localparam int MaxCpus  = 16;
	localparam int NumLines = 16;

	localparam logic [1:0] FUNC_READ  = 2'd0;
	localparam logic [1:0] FUNC_WRITE = 2'd1;
	localparam logic [1:0] FUNC_LINE  = 2'd2;
	localparam logic [1:0] FUNC_ACK   = 2'd3;

	localparam logic [7:0] OFS_LEVEL   = 8'h00;
	localparam logic [7:0] OFS_PENDING = 8'h04;
	localparam logic [7:0] OFS_FORCE0  = 8'h08;
	localparam logic [7:0] OFS_CLEAR   = 8'h0C;
	localparam logic [7:0] OFS_STATUS  = 8'h10;
	localparam logic [7:0] OFS_BCAST   = 8'h14;

	typedef struct packed {
		logic [1:0]  func;
		logic [7:0]  reg_addr;
		logic [31:0] write_data;
		logic [3:0]  irq_line;
		logic        irq_level;
		logic [3:0]  ack_cpu;
		logic [3:0]  ack_number;
	} cmd_t;

endpackage

// ----- design/mpic_front.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mpic_front
// Input stage: registers transactions into a two-entry queue.
// ----------------------------------------------------------------------------
module mpic_front (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_ready,
	input  mpic_pkg::cmd_t  in_cmd,
	output logic            q_valid,
	input  logic            q_ready,
	output mpic_pkg::cmd_t  q_cmd
);
	import mpic_pkg::*;

	cmd_t       mem_q [2];
	logic       wp_q, rp_q;
	logic [1:0] cnt_q;

	assign in_ready = (cnt_q != 2'd2);
	assign q_valid  = (cnt_q != 2'd0);
	assign q_cmd    = mem_q[rp_q];

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) mem_q[wp_q] <= in_cmd;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (in_valid && in_ready) wp_q <= ~wp_q;
			if (q_valid && q_ready) rp_q <= ~rp_q;
			cnt_q <= cnt_q + 2'(in_valid && in_ready) - 2'(q_valid && q_ready);
		end
	end

endmodule

// ----- design/mpic_back.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mpic_back
// Register file and per-processor result sequencer.
// ----------------------------------------------------------------------------
module mpic_back #(
	parameter int MAX_CPUS = mpic_pkg::MaxCpus
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            cfg_valid,
	output logic            cfg_ready,
	input  logic [4:0]      cfg_data,
	input  logic            q_valid,
	output logic            q_ready,
	input  mpic_pkg::cmd_t  q_cmd,
	output logic            out_valid,
	input  logic            out_ready,
	output logic [3:0]      cpu_index,
	output logic [15:0]     request_vector,
	output logic            start_pulse,
	output logic [31:0]     read_data,
	output logic            last
);
	import mpic_pkg::*;

	typedef enum logic [1:0] {ST_IDLE = 2'b01, ST_EMIT = 2'b10} state_t;

	state_t      state_q;
	logic [4:0]  count_q;
	logic [16:0] level_q;
	logic [15:0] pend_q, bcast_q, starts_q;
	logic [31:0] status_q, rdata_q;
	logic [31:0] mask_q [MAX_CPUS];
	logic [15:0] force_q [MAX_CPUS];
	logic [3:0]  ext_q [MAX_CPUS];
	logic [3:0]  idx_q;

	logic [4:0]  cfg_eff;
	logic [3:0]  slot;
	logic [31:0] rd;
	logic [15:0] p, hi, lo, lbit;
	logic [15:0] sv;
	logic        emit_done;

	function automatic logic [31:0] status_for(logic [4:0] n);
		logic [31:0] s;
		s = {4'(n - 5'd1), 28'd0};
		s[27:0] = 28'(((32'd1 << n) - 32'd2) & 32'hFFFF);
		return s;
	endfunction

	assign cfg_eff = (cfg_data == 5'd0) ? 5'd1 :
		(cfg_data > 5'(MAX_CPUS)) ? 5'(MAX_CPUS) : cfg_data;
	assign cfg_ready = (state_q == ST_IDLE);
	assign q_ready   = (state_q == ST_IDLE) && !cfg_valid;
	assign slot      = q_cmd.reg_addr[5:2];
	assign lbit      = 16'd1 << q_cmd.irq_line;
	assign sv        = q_cmd.write_data[15:0] & 16'(((32'd1 << MAX_CPUS) - 32'd2) & 32'hFFFF)
		& 16'((32'd1 << count_q) - 32'd1);

	always_comb begin
		rd = 32'd0;
		case (q_cmd.reg_addr[7:6])
			2'd0: begin
				case (q_cmd.reg_addr)
					OFS_LEVEL:   rd = 32'(level_q);
					OFS_PENDING: rd = 32'(pend_q);
					OFS_FORCE0:  rd = 32'(force_q[0]);
					OFS_STATUS:  rd = status_q;
					OFS_BCAST:   rd = 32'(bcast_q);
					default:     rd = 32'd0;
				endcase
			end
			2'd1: rd = (32'(slot) < MAX_CPUS) ? mask_q[slot] : 32'd0;
			2'd2: rd = (32'(slot) < MAX_CPUS) ? 32'(force_q[slot]) : 32'd0;
			default: rd = (32'(slot) < MAX_CPUS) ? 32'(ext_q[slot]) : 32'd0;
		endcase
	end

	assign p  = (pend_q | force_q[idx_q]) & mask_q[idx_q][15:0];
	assign hi = p & level_q[15:0];
	assign lo = p & ~level_q[15:0];

	assign out_valid      = (state_q == ST_EMIT);
	assign cpu_index      = idx_q;
	assign request_vector = (hi != 16'd0) ? hi : lo;
	assign start_pulse    = starts_q[idx_q];
	assign read_data      = rdata_q;
	assign last           = (5'(idx_q) + 5'd1 == count_q);
	assign emit_done      = out_valid && out_ready && last;

	always_ff @(posedge clk) begin
		if (q_valid && q_ready) begin
			rdata_q  <= (q_cmd.func == FUNC_READ) ? rd : 32'd0;
			starts_q <= (q_cmd.func == FUNC_WRITE && q_cmd.reg_addr == OFS_STATUS) ? sv : 16'd0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			count_q  <= 5'd1;
			level_q  <= '0;
			pend_q   <= '0;
			bcast_q  <= '0;
			status_q <= status_for(5'd1);
			idx_q    <= '0;
			for (int i = 0; i < MAX_CPUS; i++) begin
				mask_q[i]  <= '0;
				force_q[i] <= '0;
				ext_q[i]   <= '0;
			end
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (cfg_valid) begin
						count_q <= cfg_eff;
						if (cfg_eff != count_q) status_q <= status_for(cfg_eff);
					end else if (q_valid) begin
						state_q <= ST_EMIT;
						idx_q   <= '0;
						case (q_cmd.func)
							FUNC_WRITE: begin
								case (q_cmd.reg_addr[7:6])
									2'd0: begin
										case (q_cmd.reg_addr)
											OFS_LEVEL: level_q <= {q_cmd.write_data[16:1], 1'b0};
											OFS_FORCE0: force_q[0] <= q_cmd.write_data[15:0] & 16'hFFFE;
											OFS_CLEAR: begin
												pend_q <= pend_q & ~(q_cmd.write_data[15:0] & 16'hFFFE);
												for (int i = 0; i < MAX_CPUS; i++)
													if (5'(i) < count_q)
														force_q[i] <= force_q[i]
															& ~(q_cmd.write_data[15:0] & 16'hFFFE);
											end
											OFS_STATUS: status_q <= status_q & ~32'(sv);
											OFS_BCAST: bcast_q <= q_cmd.write_data[15:0] & 16'hFFFE;
											default: ;
										endcase
									end
									2'd1: if (32'(slot) < MAX_CPUS)
										mask_q[slot] <= q_cmd.write_data & 32'hFFFF_FFFE;
									2'd2: if (32'(slot) < MAX_CPUS)
										force_q[slot] <= (force_q[slot]
											| (q_cmd.write_data[15:0] & 16'hFFFE))
											& ~(q_cmd.write_data[31:16] & 16'hFFFE);
									default: if (32'(slot) < MAX_CPUS)
										ext_q[slot] <= q_cmd.write_data[3:0];
								endcase
							end
							FUNC_LINE: begin
								if (q_cmd.irq_level) begin
									if ((bcast_q & lbit) != 16'd0) begin
										for (int i = 0; i < MAX_CPUS; i++)
											force_q[i] <= force_q[i] | lbit;
									end else begin
										pend_q <= pend_q | lbit;
									end
								end
							end
							FUNC_ACK: begin
								pend_q <= pend_q & ~(16'd1 << q_cmd.ack_number);
								if (32'(q_cmd.ack_cpu) < MAX_CPUS)
									force_q[q_cmd.ack_cpu] <= force_q[q_cmd.ack_cpu]
										& ~(16'd1 << q_cmd.ack_number);
							end
							default: ;
						endcase
					end
				end
				ST_EMIT: begin
					if (out_ready) begin
						idx_q <= idx_q + 4'd1;
						if (emit_done) state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

// ----- design/multiprocessor_interrupt_controller_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// multiprocessor_interrupt_controller_top
// 16-line interrupt controller for up to MAX_CPUS processors.
// ----------------------------------------------------------------------------
// Input channel (in_valid/in_ready) carries one transaction: register read,
// register write, line raise or processor acknowledge. A two-entry queue
// decouples it from the executor. The executor applies the transaction,
// then emits one result per configured processor on the output
// channel (out_valid/out_ready), last set on the final one.
// The result sequencer takes no new transaction from the queue until
// the last result of the current one has been taken.
// The output stalls freely; the queue keeps taking up to two transactions.
// cfg channel writes cpu_count (0 acts as 1, above MAX_CPUS as MAX_CPUS);
// taken only between transactions, it reloads the status word on change.
// Reset: control and interrupt state cleared, one processor, status word for one processor.
// ----------------------------------------------------------------------------
module multiprocessor_interrupt_controller_top #(
	parameter int MAX_CPUS = mpic_pkg::MaxCpus
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [4:0]  cfg_data,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  func,
	input  logic [7:0]  reg_addr,
	input  logic [31:0] write_data,
	input  logic [3:0]  irq_line,
	input  logic        irq_level,
	input  logic [3:0]  ack_cpu,
	input  logic [3:0]  ack_number,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [3:0]  cpu_index,
	output logic [15:0] request_vector,
	output logic        start_pulse,
	output logic [31:0] read_data,
	output logic        last
);
	import mpic_pkg::*;

	cmd_t in_cmd, q_cmd;
	logic q_valid, q_ready;

	assign in_cmd = '{func: func, reg_addr: reg_addr, write_data: write_data,
		irq_line: irq_line, irq_level: irq_level, ack_cpu: ack_cpu,
		ack_number: ack_number};

	mpic_front u_front (
		.clk, .arst_n, .in_valid, .in_ready, .in_cmd,
		.q_valid, .q_ready, .q_cmd
	);

	mpic_back #(.MAX_CPUS(MAX_CPUS)) u_back (
		.clk, .arst_n, .cfg_valid, .cfg_ready, .cfg_data,
		.q_valid, .q_ready, .q_cmd,
		.out_valid, .out_ready, .cpu_index, .request_vector,
		.start_pulse, .read_data, .last
	);

endmodule
